// File: src/rpbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpbq_pkg
// Shared types and constants of the ray pick box table query block.
// ----------------------------------------------------------------------------
package rpbq_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam int COORD_W  = 32;
    localparam int TAG_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int S_TDATA_W = 232;
    localparam int M_TDATA_W = 64;

    localparam int BOX_W   = 6 * COORD_W;
    localparam int ENTRY_W = BOX_W + TAG_W;

    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = 6;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + COORD_W;

    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        HIT_NONE   = 2'd0,
        HIT_GROUND = 2'd1,
        HIT_BOX    = 2'd2
    } hit_kind_t;

    typedef enum logic [1:0] {
        DIV_GROUND = 2'd0,
        DIV_AXIS_X = 2'd1,
        DIV_AXIS_Y = 2'd2,
        DIV_AXIS_Z = 2'd3
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLOAD,
        ST_DSTEP,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: src/ray_pick_box_table_query.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_pick_box_table_query
// Ray pick against a table of axis-aligned boxes and the ground plane y = 0.
// ----------------------------------------------------------------------------
// A load word (s_tuser = 0) writes one table entry and is answered in the next
// cycle with an all-zero result word. A query word (s_tuser = 1) runs through
// one shared restoring divider, one quotient bit per cycle: one division for
// the ground distance when the ground test applies, and one for each nonzero
// direction component when boxes are tested; a skipped division is passed
// over in the load state. The box scan then streams the entry memory at one
// entry per cycle through a slab pipeline. The next word is taken once the
// result word of a query has risen and the block is back in idle; one item
// is worked on at a time. The valid bits reset to zero at once, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module ray_pick_box_table_query #(
    parameter int MAX_ENTRIES = rpbq_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // slot, entry_is_target, tag_hash, coord_a_x, coord_a_y, coord_a_z,
    // coord_b_x, coord_b_y, coord_b_z, want_ground, want_boxes
    input  wire logic [rpbq_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // ground_distance, hit_tag
    output logic [rpbq_pkg::M_TDATA_W-1:0]       m_tdata,
    // hit_kind
    output logic [1:0]                           m_tuser
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = rpbq_pkg::COORD_W;

    // input fields
    logic [rpbq_pkg::SLOT_W-1:0] in_slot;
    logic                        in_target;
    logic [rpbq_pkg::TAG_W-1:0]  in_tag;
    logic signed [CW-1:0]        in_a [3];
    logic signed [CW-1:0]        in_b [3];
    logic                        in_want_ground;
    logic                        in_want_boxes;
    logic                        s_accept;
    logic                        m_accept;
    logic                        slot_ok;
    logic [IDX_W-1:0]            wr_idx;

    assign in_slot        = s_tdata[4:0];
    assign in_target      = s_tdata[5];
    assign in_tag         = s_tdata[37:6];
    assign in_a[0]        = s_tdata[69:38];
    assign in_a[1]        = s_tdata[101:70];
    assign in_a[2]        = s_tdata[133:102];
    assign in_b[0]        = s_tdata[165:134];
    assign in_b[1]        = s_tdata[197:166];
    assign in_b[2]        = s_tdata[229:198];
    assign in_want_ground = s_tdata[230];
    assign in_want_boxes  = s_tdata[231];

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign slot_ok  = 32'(in_slot) < 32'(MAX_ENTRIES);
    assign wr_idx   = IDX_W'(in_slot);

    // control state
    rpbq_pkg::state_t   state_reg, state_next;
    rpbq_pkg::div_sel_t div_sel_reg;
    logic [rpbq_pkg::STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]            issue_cnt_reg;
    logic [MAX_ENTRIES-1:0]      valid_reg;
    logic                        p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic                        m_tvalid_reg;

    // query state
    logic signed [CW-1:0]        org_reg [3];
    logic signed [CW-1:0]        dir_reg [3];
    logic signed [CW-1:0]        inv_reg [3];
    logic                        want_ground_reg;
    logic                        want_boxes_reg;
    rpbq_pkg::hit_kind_t         res_kind_reg;
    logic [CW-1:0]               res_dist_reg;
    logic [rpbq_pkg::TAG_W-1:0]  res_tag_reg;

    // output registers
    rpbq_pkg::hit_kind_t         out_kind_reg;
    logic [CW-1:0]               out_dist_reg;
    logic [rpbq_pkg::TAG_W-1:0]  out_tag_reg;

    // divider
    logic [CW-1:0]               rem_reg;
    logic [rpbq_pkg::DIV_W-1:0]  quo_reg;
    logic [CW-1:0]               dvs_reg;
    logic                        div_neg_reg;
    logic [CW:0]                 div_sh;
    logic                        div_ge;
    logic [CW:0]                 div_sub;
    logic [CW-1:0]               rem_next;
    logic [rpbq_pkg::DIV_W-1:0]  quo_next;
    logic [CW-1:0]               q_sat;
    logic                        div_last;

    // divider load decision
    logic                        ground_ok;
    logic signed [CW-1:0]        cur_dir;
    logic [CW-1:0]               oy_mag;
    logic [CW-1:0]               dy_mag;
    logic [CW-1:0]               cur_mag;
    logic                        div_need;
    logic                        div_zero;

    // memory and scan pipeline
    logic [rpbq_pkg::ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [rpbq_pkg::ENTRY_W-1:0] mem_rd_reg;
    logic                         issue;
    logic [IDX_W-1:0]             rd_idx;
    logic                         scan_done;
    logic                         p1_ent_reg;
    logic                         p2_ent_reg;
    logic                         p3_ent_reg;
    logic                         p4_ent_reg;
    logic [rpbq_pkg::TAG_W-1:0]   p2_tag_reg, p3_tag_reg, p4_tag_reg;
    logic signed [rpbq_pkg::DIFF_W-1:0] p2_dn_reg [3];
    logic signed [rpbq_pkg::DIFF_W-1:0] p2_df_reg [3];
    logic signed [rpbq_pkg::PROD_W-1:0] p3_tn_reg [3];
    logic signed [rpbq_pkg::PROD_W-1:0] p3_tf_reg [3];
    logic                               p4_fail_reg;
    logic signed [rpbq_pkg::PROD_W-1:0] p4_lo_reg, p4_hi_reg, p4_tn_reg, p4_tf_reg;
    logic signed [CW-1:0]               rd_min [3];
    logic signed [CW-1:0]               rd_max [3];
    logic                               box_hit;

    assign issue     = (state_reg == rpbq_pkg::ST_SCAN) && (issue_cnt_reg < CNT_W'(MAX_ENTRIES));
    assign rd_idx    = issue_cnt_reg[IDX_W-1:0];
    assign scan_done = (issue_cnt_reg == CNT_W'(MAX_ENTRIES)) &&
                       !p1_vld_reg && !p2_vld_reg && !p3_vld_reg && !p4_vld_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rd_min[a] = mem_rd_reg[a*CW +: CW];
            rd_max[a] = mem_rd_reg[(a+3)*CW +: CW];
        end
    end

    assign box_hit = p4_ent_reg && !p4_fail_reg &&
                     !((p4_lo_reg > p4_tf_reg) || (p4_tn_reg > p4_hi_reg));

    // divider datapath
    assign div_sh   = {rem_reg, quo_reg[rpbq_pkg::DIV_W-1]};
    assign div_ge   = div_sh >= {1'b0, dvs_reg};
    assign div_sub  = div_sh - {1'b0, dvs_reg};
    assign rem_next = div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0];
    assign quo_next = {quo_reg[rpbq_pkg::DIV_W-2:0], div_ge};
    assign q_sat    = (|quo_next[rpbq_pkg::DIV_W-1:CW-1]) ? rpbq_pkg::SAT_MAX
                                                          : quo_next[CW-1:0];
    assign div_last = step_reg == rpbq_pkg::STEP_W'(rpbq_pkg::DIV_STEPS - 1);

    always_comb begin
        unique case (div_sel_reg)
            rpbq_pkg::DIV_AXIS_X: cur_dir = dir_reg[0];
            rpbq_pkg::DIV_AXIS_Y: cur_dir = dir_reg[1];
            rpbq_pkg::DIV_AXIS_Z: cur_dir = dir_reg[2];
            default:              cur_dir = dir_reg[1];
        endcase
    end

    assign oy_mag    = org_reg[1][CW-1] ? CW'(-org_reg[1]) : org_reg[1];
    assign dy_mag    = dir_reg[1][CW-1] ? CW'(-dir_reg[1]) : dir_reg[1];
    assign cur_mag   = cur_dir[CW-1] ? CW'(-cur_dir) : cur_dir;
    assign ground_ok = (dir_reg[1] != '0) &&
                       ((org_reg[1] == '0) || (org_reg[1][CW-1] != dir_reg[1][CW-1]));
    assign div_zero  = cur_dir == '0;
    assign div_need  = (div_sel_reg == rpbq_pkg::DIV_GROUND) ? (want_ground_reg && ground_ok)
                                                             : (want_boxes_reg && !div_zero);

    // next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            rpbq_pkg::ST_IDLE: begin
                s_tready = !m_tvalid_reg || m_tready;
                if (s_accept && s_tuser) begin
                    state_next = rpbq_pkg::ST_DLOAD;
                end
            end
            rpbq_pkg::ST_DLOAD: begin
                if (div_need) begin
                    state_next = rpbq_pkg::ST_DSTEP;
                end else if (div_sel_reg == rpbq_pkg::DIV_AXIS_Z) begin
                    state_next = want_boxes_reg ? rpbq_pkg::ST_SCAN : rpbq_pkg::ST_DONE;
                end
            end
            rpbq_pkg::ST_DSTEP: begin
                if (div_last) begin
                    if (div_sel_reg == rpbq_pkg::DIV_AXIS_Z) begin
                        state_next = want_boxes_reg ? rpbq_pkg::ST_SCAN : rpbq_pkg::ST_DONE;
                    end else begin
                        state_next = rpbq_pkg::ST_DLOAD;
                    end
                end
            end
            rpbq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = rpbq_pkg::ST_DONE;
                end
            end
            rpbq_pkg::ST_DONE: begin
                if (!m_tvalid_reg) begin
                    state_next = rpbq_pkg::ST_IDLE;
                end
            end
            default: state_next = rpbq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpbq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (s_accept && !s_tuser && slot_ok) begin
            mem[wr_idx] <= {in_tag, in_b[2], in_b[1], in_b[0], in_a[2], in_a[1], in_a[0]};
        end
        if (issue) begin
            mem_rd_reg <= mem[rd_idx];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            p4_vld_reg    <= 1'b0;
            div_sel_reg   <= rpbq_pkg::DIV_GROUND;
            step_reg      <= '0;
            issue_cnt_reg <= '0;
        end else begin
            if ((s_accept && !s_tuser) ||
                (state_reg == rpbq_pkg::ST_DONE && !m_tvalid_reg)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_accept) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept && !s_tuser && slot_ok) begin
                valid_reg[wr_idx] <= in_target;
            end
            if (s_accept) begin
                div_sel_reg   <= rpbq_pkg::DIV_GROUND;
                issue_cnt_reg <= '0;
            end
            if (state_reg == rpbq_pkg::ST_DLOAD) begin
                step_reg <= '0;
                if (!div_need && div_sel_reg != rpbq_pkg::DIV_AXIS_Z) begin
                    div_sel_reg <= rpbq_pkg::div_sel_t'(div_sel_reg + 2'd1);
                end
            end
            if (state_reg == rpbq_pkg::ST_DSTEP) begin
                step_reg <= step_reg + rpbq_pkg::STEP_W'(1);
                if (div_last && div_sel_reg != rpbq_pkg::DIV_AXIS_Z) begin
                    div_sel_reg <= rpbq_pkg::div_sel_t'(div_sel_reg + 2'd1);
                end
            end
            if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser) begin
            for (int a = 0; a < 3; a++) begin
                org_reg[a] <= in_a[a];
                dir_reg[a] <= in_b[a];
                inv_reg[a] <= rpbq_pkg::SAT_MAX;
            end
            want_ground_reg <= in_want_ground;
            want_boxes_reg  <= in_want_boxes;
            res_kind_reg    <= rpbq_pkg::HIT_NONE;
            res_dist_reg    <= '0;
            res_tag_reg     <= '0;
        end
        if (state_reg == rpbq_pkg::ST_DLOAD) begin
            rem_reg <= '0;
            if (div_sel_reg == rpbq_pkg::DIV_GROUND) begin
                quo_reg     <= {oy_mag, 16'h0000};
                dvs_reg     <= dy_mag;
                div_neg_reg <= 1'b0;
            end else begin
                quo_reg     <= rpbq_pkg::DIV_W'(64'h1_0000_0000);
                dvs_reg     <= cur_mag;
                div_neg_reg <= cur_dir[CW-1];
            end
        end
        if (state_reg == rpbq_pkg::ST_DSTEP) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (div_last) begin
                case (div_sel_reg)
                    rpbq_pkg::DIV_GROUND: begin
                        res_kind_reg <= rpbq_pkg::HIT_GROUND;
                        res_dist_reg <= q_sat;
                    end
                    rpbq_pkg::DIV_AXIS_X: inv_reg[0] <= div_neg_reg ? CW'(-q_sat) : q_sat;
                    rpbq_pkg::DIV_AXIS_Y: inv_reg[1] <= div_neg_reg ? CW'(-q_sat) : q_sat;
                    default:              inv_reg[2] <= div_neg_reg ? CW'(-q_sat) : q_sat;
                endcase
            end
        end
        if (p4_vld_reg && box_hit) begin
            res_kind_reg <= rpbq_pkg::HIT_BOX;
            res_tag_reg  <= p4_tag_reg;
        end

        // slab pipeline
        p1_ent_reg <= valid_reg[rd_idx];
        p2_ent_reg <= p1_ent_reg;
        p2_tag_reg <= mem_rd_reg[rpbq_pkg::ENTRY_W-1:rpbq_pkg::BOX_W];
        for (int a = 0; a < 3; a++) begin
            if (inv_reg[a][CW-1]) begin
                p2_dn_reg[a] <= $signed({rd_max[a][CW-1], rd_max[a]})
                              - $signed({org_reg[a][CW-1], org_reg[a]});
                p2_df_reg[a] <= $signed({rd_min[a][CW-1], rd_min[a]})
                              - $signed({org_reg[a][CW-1], org_reg[a]});
            end else begin
                p2_dn_reg[a] <= $signed({rd_min[a][CW-1], rd_min[a]})
                              - $signed({org_reg[a][CW-1], org_reg[a]});
                p2_df_reg[a] <= $signed({rd_max[a][CW-1], rd_max[a]})
                              - $signed({org_reg[a][CW-1], org_reg[a]});
            end
            p3_tn_reg[a] <= p2_dn_reg[a] * inv_reg[a];
            p3_tf_reg[a] <= p2_df_reg[a] * inv_reg[a];
        end
        p3_ent_reg  <= p2_ent_reg;
        p3_tag_reg  <= p2_tag_reg;
        p4_ent_reg  <= p3_ent_reg;
        p4_tag_reg  <= p3_tag_reg;
        p4_fail_reg <= (p3_tn_reg[0] > p3_tf_reg[1]) || (p3_tn_reg[1] > p3_tf_reg[0]);
        p4_lo_reg   <= (p3_tn_reg[1] > p3_tn_reg[0]) ? p3_tn_reg[1] : p3_tn_reg[0];
        p4_hi_reg   <= (p3_tf_reg[1] < p3_tf_reg[0]) ? p3_tf_reg[1] : p3_tf_reg[0];
        p4_tn_reg   <= p3_tn_reg[2];
        p4_tf_reg   <= p3_tf_reg[2];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (s_accept && !s_tuser) begin
            out_kind_reg <= rpbq_pkg::HIT_NONE;
            out_dist_reg <= '0;
            out_tag_reg  <= '0;
        end
        if (state_reg == rpbq_pkg::ST_DONE && !m_tvalid_reg) begin
            out_kind_reg <= res_kind_reg;
            out_dist_reg <= res_dist_reg;
            out_tag_reg  <= res_tag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_tag_reg, out_dist_reg};
    assign m_tuser  = out_kind_reg;

    // checks
    a_load_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tuser |=> m_tvalid && m_tuser == rpbq_pkg::HIT_NONE)
        else $error("load word not acknowledged with empty result");

    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rpbq_pkg::ST_DONE && !m_tvalid_reg |=> m_tvalid_reg)
        else $error("finished query did not raise result");

    a_pipe_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        p4_vld_reg |-> state_reg == rpbq_pkg::ST_SCAN)
        else $error("slab pipeline active outside scan");

    a_tag_only_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rpbq_pkg::HIT_BOX |-> m_tdata[63:32] == '0)
        else $error("tag reported without box hit");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser |=> !s_tready)
        else $error("input taken while query in progress");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the ray pick box table query block: loads box table
// entries and casts rays, predicting each hit word and comparing it in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_RANDOM = 450;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        mode;
        logic [4:0]  slot;
        logic        target;
        logic [31:0] tag;
        logic [31:0] ax, ay, az, bx, by, bz;
        logic        want_ground;
        logic        want_boxes;
    } ray_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] gnd_dist;
        logic [31:0] tag;
    } pick_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rpbq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rpbq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    logic signed [31:0] mdl_box [32][6];
    logic [31:0] mdl_tag [32];
    logic mdl_valid [32];

    pick_t pending_picks[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    ray_pick_box_table_query u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint recip(longint d);
        longint q;
        longint mag;
        if (d == 0) return 64'sh7FFFFFFF;
        mag = (d < 0) ? -d : d;
        q = 64'sh100000000 / mag;
        if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
        return (d < 0) ? -q : q;
    endfunction

    function automatic bit slab_hit(int e, longint org[3], longint inv[3]);
        longint lo, hi, nb, fb, tn, tf;
        lo = 0;
        hi = 0;
        for (int ax = 0; ax < 3; ax++) begin
            nb = (inv[ax] < 0) ? longint'(mdl_box[e][ax+3]) : longint'(mdl_box[e][ax]);
            fb = (inv[ax] < 0) ? longint'(mdl_box[e][ax]) : longint'(mdl_box[e][ax+3]);
            tn = (nb - org[ax]) * inv[ax];
            tf = (fb - org[ax]) * inv[ax];
            if (ax == 0) begin
                lo = tn;
                hi = tf;
            end else begin
                if (lo > tf || tn > hi) return 1'b0;
                if (tn > lo) lo = tn;
                if (tf < hi) hi = tf;
            end
        end
        return 1'b1;
    endfunction

    function automatic pick_t predict_pick(ray_word_t w);
        pick_t p;
        longint org[3], inv[3], oy, dy, num, den, q;
        p = '0;
        org[0] = longint'(signed'(w.ax));
        org[1] = longint'(signed'(w.ay));
        org[2] = longint'(signed'(w.az));
        if (!w.mode) begin
            mdl_box[w.slot] = '{w.ax, w.ay, w.az, w.bx, w.by, w.bz};
            mdl_tag[w.slot] = w.tag;
            mdl_valid[w.slot] = w.target;
            return p;
        end
        if (w.want_ground) begin
            oy = org[1];
            dy = longint'(signed'(w.by));
            if (dy != 0 && (oy == 0 || ((oy < 0) != (dy < 0)))) begin
                num = ((oy < 0) ? -oy : oy) <<< 16;
                den = (dy < 0) ? -dy : dy;
                q = num / den;
                if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
                p.kind = rpbq_pkg::HIT_GROUND;
                p.gnd_dist = q[31:0];
            end
        end
        if (w.want_boxes) begin
            inv[0] = recip(longint'(signed'(w.bx)));
            inv[1] = recip(longint'(signed'(w.by)));
            inv[2] = recip(longint'(signed'(w.bz)));
            for (int e = 0; e < 32; e++) begin
                if (mdl_valid[e] && slab_hit(e, org, inv)) begin
                    p.kind = rpbq_pkg::HIT_BOX;
                    p.tag = mdl_tag[e];
                end
            end
        end
        return p;
    endfunction

    task automatic send_word(ray_word_t w, bit use_fixed, pick_t fixed);
        pick_t p;
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.mode;
        s_tdata <= {w.want_boxes, w.want_ground, w.bz, w.by, w.bx, w.az, w.ay, w.ax,
                    w.tag, w.target, w.slot};
        p = predict_pick(w);
        pending_picks.push_back(use_fixed ? fixed : p);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
        endcase
    endfunction

    function automatic ray_word_t rand_word();
        ray_word_t w;
        w.mode = ($urandom_range(0, 2) != 0);
        w.slot = 5'($urandom);
        w.target = ($urandom_range(0, 4) != 0);
        w.tag = $urandom;
        w.ax = rand_coord();
        w.ay = rand_coord();
        w.az = rand_coord();
        w.bx = rand_coord();
        w.by = rand_coord();
        w.bz = rand_coord();
        if (!w.mode && $urandom_range(0, 3) != 0) begin
            w.bx = w.ax + $urandom_range(0, 32'h0008_0000);
            w.by = w.ay + $urandom_range(0, 32'h0008_0000);
            w.bz = w.az + $urandom_range(0, 32'h0008_0000);
        end
        w.want_ground = 1'($urandom);
        w.want_boxes = 1'($urandom);
        return w;
    endfunction

    always @(posedge aclk) begin
        pick_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected word kind=%0d data=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                exp_p = pending_picks.pop_front();
                if (m_tuser !== exp_p.kind)
                    $display("%0t: hit_kind expected %0d actual %0d", $time, exp_p.kind,
                             m_tuser);
                if (m_tdata[31:0] !== exp_p.gnd_dist)
                    $display("%0t: ground_distance expected %h actual %h", $time,
                             exp_p.gnd_dist, m_tdata[31:0]);
                if (m_tdata[63:32] !== exp_p.tag)
                    $display("%0t: hit_tag expected %h actual %h", $time, exp_p.tag,
                             m_tdata[63:32]);
                if (m_tuser !== exp_p.kind || m_tdata !== {exp_p.tag, exp_p.gnd_dist})
                    errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        ray_word_t w;
        ray_word_t rows[$];
        pick_t fixed[$];
        bit use_fixed[$];
        pick_t zero_pick;
        zero_pick = '0;
        for (int e = 0; e < 32; e++) mdl_valid[e] = 1'b0;

        // queries on an empty table
        w = '0; w.mode = 1'b1; w.want_ground = 1'b1; w.want_boxes = 1'b1;
        w.ay = 32'h0001_0000; w.by = 32'hFFFF_0000;
        rows.push_back(w); use_fixed.push_back(1'b1);
        fixed.push_back(pick_t'{rpbq_pkg::HIT_GROUND, 32'h0001_0000, 32'h0});
        w.ay = 32'h0; w.by = 32'h0;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w.ay = 32'h7FFF_FFFF; w.by = 32'hFFFF_FFFF;
        rows.push_back(w); use_fixed.push_back(1'b1);
        fixed.push_back(pick_t'{rpbq_pkg::HIT_GROUND, 32'h7FFF_FFFF, 32'h0});
        w.ay = 32'h8000_0000; w.by = 32'h8000_0000;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w.ay = 32'h0; w.by = 32'h0001_0000;
        rows.push_back(w); use_fixed.push_back(1'b1);
        fixed.push_back(pick_t'{rpbq_pkg::HIT_GROUND, 32'h0, 32'h0});
        // loads: unit box, inverted box, extreme box, cleared entry
        w = '0; w.slot = 5'd0; w.target = 1'b1; w.tag = 32'hFFFF_FFFF;
        w.bx = 32'h0001_0000; w.by = 32'h0001_0000; w.bz = 32'h0001_0000;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w.slot = 5'd3; w.tag = 32'h1234_5678;
        w.ax = 32'h0005_0000; w.bx = 32'h0001_0000;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w.slot = 5'd31; w.tag = 32'hA5A5_5A5A;
        w.ax = 32'h8000_0000; w.ay = 32'h8000_0000; w.az = 32'h8000_0000;
        w.bx = 32'h7FFF_FFFF; w.by = 32'h7FFF_FFFF; w.bz = 32'h7FFF_FFFF;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w.slot = 5'd12; w.target = 1'b0; w.tag = 32'hDEAD_BEEF;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        // box queries: zero direction, negative dirs, extremes, box only, neither
        w = '0; w.mode = 1'b1; w.want_boxes = 1'b1;
        w.ax = 32'hFFFF_0000; w.ay = 32'h0000_8000; w.az = 32'h0000_8000;
        w.bx = 32'h0001_0000;
        rows.push_back(w); use_fixed.push_back(1'b0); fixed.push_back(zero_pick);
        w.ax = 32'h0003_0000; w.bx = 32'hFFFF_0000; w.by = 32'hFFFF_FFFF;
        w.bz = 32'h8000_0000; w.want_ground = 1'b1;
        rows.push_back(w); use_fixed.push_back(1'b0); fixed.push_back(zero_pick);
        w.ax = 32'h7FFF_FFFF; w.ay = 32'h8000_0000; w.bx = 32'h7FFF_FFFF;
        w.by = 32'h0000_0001; w.bz = 32'h0;
        rows.push_back(w); use_fixed.push_back(1'b0); fixed.push_back(zero_pick);
        w.want_ground = 1'b0; w.want_boxes = 1'b0;
        rows.push_back(w); use_fixed.push_back(1'b1); fixed.push_back(zero_pick);
        w = '0; w.mode = 1'b1; w.want_boxes = 1'b1; w.ax = 32'h0010_0000;
        w.bx = 32'h0001_0000;
        rows.push_back(w); use_fixed.push_back(1'b0); fixed.push_back(zero_pick);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) send_word(rows[i], use_fixed[i], fixed[i]);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 100) hold_off = 1'b1;
            if (n == 250) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_picks.size() != 0) @(posedge aclk);
            end
            send_word(rand_word(), 1'b0, zero_pick);
        end
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending_picks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
